### design/bsa_pkg.sv
// bsa_pkg: shared types, sizes and codes for the banker's safe allocator
// no dependencies; imported by bsa_lane and bankers_safe_allocator
package bsa_pkg;

    localparam int NPROC     = 5;
    localparam int NRES      = 5;
    localparam int UNIT_W    = 4;
    localparam int VEC_W     = NRES * UNIT_W;
    localparam int PIDX_W    = $clog2(NPROC);
    // work vector holds free units plus everything held, so it never wraps
    localparam int WORK_W    = UNIT_W + $clog2(NPROC + 1);
    localparam int CFG_IDX_W = 3;

    // register index of the total-units register, claims sit below it
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = CFG_IDX_W'(NPROC);

    // command decode: bit 1 alone selects clear
    localparam int         CMD_CLEAR_BIT = 1;
    localparam logic [1:0] CMD_RELEASE   = 2'd1;

    localparam logic [VEC_W-1:0] TOTAL_RESET = 20'h11111;
    localparam logic [VEC_W-1:0] FREE_RESET  = 20'h11111;
    localparam logic [NPROC-1:0][VEC_W-1:0] CLAIM_RESET =
        {20'd17, 20'd24, 20'd12, 20'd6, 20'd3};

    typedef enum logic [2:0] {
        ST_GRANTED    = 3'd0,
        ST_NOT_FREE   = 3'd1,
        ST_UNSAFE     = 3'd2,
        ST_OVER_CLAIM = 3'd3,
        ST_RELEASED   = 3'd4,
        ST_CLEARED    = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [2:0]       proc_index;
        logic [VEC_W-1:0] request_units;
    } in_item_t;

    typedef struct packed {
        status_t          status;
        logic [VEC_W-1:0] free_units;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic add;
    } lane_ctrl_t;

endpackage

### design/bsa_lane.sv
// bsa_lane: one resource lane of the safety test, need vs work compare
// depends on bsa_pkg
module bsa_lane
    import bsa_pkg::*;
(
    input  logic              clk,
    input  lane_ctrl_t        ctrl,
    input  logic [UNIT_W-1:0] seed,
    input  logic [UNIT_W-1:0] claim,
    input  logic [UNIT_W-1:0] held,
    output logic              ok
);

    logic [WORK_W-1:0] work_reg;
    logic [WORK_W-1:0] work_next;
    logic [UNIT_W-1:0] need;

    // held above claim means nothing more is needed
    assign need = (claim > held) ? (claim - held) : '0;
    assign ok   = WORK_W'(need) <= work_reg;

    always_comb
    begin
        work_next = work_reg;
        if (ctrl.load)
        begin
            work_next = WORK_W'(seed);
        end
        else if (ctrl.add)
        begin
            work_next = work_reg + WORK_W'(held);
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

endmodule

### design/bankers_safe_allocator.sv
// bankers_safe_allocator: clear, release and refused requests pass from accept through the
// exec and post states to out_valid; a request that runs the safety test also passes through
// the scan state, which checks one process per cycle, in whole passes only.
// one item at a time; the next item can be taken once the result is registered, even
// while that result still waits for out_ready.
// rst_n is asynchronous active low: free counts one unit each, table empty, claims default.
module bankers_safe_allocator
    import bsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VEC_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data
);

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_POST = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    in_item_t                     item_reg;

    // configuration registers
    logic [NPROC-1:0][VEC_W-1:0]  claim_reg;
    logic [VEC_W-1:0]             total_reg;

    // allocation state
    logic [VEC_W-1:0]             free_reg, free_next;
    logic [NPROC-1:0][VEC_W-1:0]  held_reg, held_next;

    // copies taken before a tentative allocation, used for rollback
    logic [VEC_W-1:0]             free_save_reg, free_save_next;
    logic [VEC_W-1:0]             held_save_reg, held_save_next;

    // safety scan bookkeeping
    logic [PIDX_W-1:0]            ptr_reg, ptr_next;
    logic [NPROC-1:0]             done_reg, done_next;
    logic                         progress_reg, progress_next;

    // result staging and output register
    status_t                      res_status_reg, res_status_next;
    logic                         out_valid_reg, out_valid_next;
    out_item_t                    out_data_reg, out_data_next;

    // shared row read: item's process in exec, scan pointer in scan
    logic                         p_ok;
    logic [PIDX_W-1:0]            p_idx;
    logic [PIDX_W-1:0]            rd_idx;
    logic [VEC_W-1:0]             held_row;
    logic [VEC_W-1:0]             claim_row;
    logic [VEC_W-1:0]             req;

    // per-resource request checks and updates
    logic [NRES-1:0]              over_vec;
    logic [NRES-1:0]              short_vec;
    logic [VEC_W-1:0]             free_tent;
    logic [VEC_W-1:0]             held_tent;
    logic [NRES-1:0][UNIT_W:0]    rel_sum;
    logic [VEC_W-1:0]             free_rel;

    // lanes and merge
    lane_ctrl_t                   lane_ctrl;
    logic                         lane_load;
    logic [NRES-1:0]              lane_ok;
    logic                         can;
    logic [NPROC-1:0]             done_upd;
    logic                         prog_now;
    logic                         last;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign req       = item_reg.request_units;
    assign p_ok      = int'(item_reg.proc_index) < NPROC;
    // out-of-range process reads row zero, the data goes unused
    assign p_idx     = p_ok ? item_reg.proc_index[PIDX_W-1:0] : '0;
    assign rd_idx    = (state_reg == S_SCAN) ? ptr_reg : p_idx;
    assign held_row  = held_reg[rd_idx];
    assign claim_row = claim_reg[rd_idx];

    // claim check, free check, tentative allocation and release, all per resource
    always_comb
    begin
        for (int j = 0; j < NRES; j++)
        begin
            over_vec[j] = ({1'b0, held_row[j*UNIT_W +: UNIT_W]}
                          + {1'b0, req[j*UNIT_W +: UNIT_W]})
                          > {1'b0, claim_row[j*UNIT_W +: UNIT_W]};
            short_vec[j] = req[j*UNIT_W +: UNIT_W] > free_reg[j*UNIT_W +: UNIT_W];
            free_tent[j*UNIT_W +: UNIT_W] = free_reg[j*UNIT_W +: UNIT_W]
                                            - req[j*UNIT_W +: UNIT_W];
            held_tent[j*UNIT_W +: UNIT_W] = held_row[j*UNIT_W +: UNIT_W]
                                            + req[j*UNIT_W +: UNIT_W];
            rel_sum[j] = {1'b0, free_reg[j*UNIT_W +: UNIT_W]}
                         + {1'b0, held_row[j*UNIT_W +: UNIT_W]};
            // release saturates at the field maximum
            free_rel[j*UNIT_W +: UNIT_W] = rel_sum[j][UNIT_W] ? '1 : rel_sum[j][UNIT_W-1:0];
        end
    end

    // one lane per resource; each keeps its own work count
    assign lane_ctrl = '{load: lane_load, add: can};

    for (genvar j = 0; j < NRES; j++)
    begin : g_lane
        bsa_lane u_lane (
            .clk   (clk),
            .ctrl  (lane_ctrl),
            .seed  (free_tent[j*UNIT_W +: UNIT_W]),
            .claim (claim_row[j*UNIT_W +: UNIT_W]),
            .held  (held_row[j*UNIT_W +: UNIT_W]),
            .ok    (lane_ok[j])
        );
    end

    // merge: the process can finish only if every lane agrees
    assign can  = (state_reg == S_SCAN) && (&lane_ok) && !done_reg[ptr_reg];
    assign last = (ptr_reg == PIDX_W'(NPROC - 1));

    always_comb
    begin
        done_upd = done_reg;
        if (can)
        begin
            done_upd[ptr_reg] = 1'b1;
        end
    end

    assign prog_now = progress_reg | can;

    // main sequencer
    always_comb
    begin
        state_next      = state_reg;
        free_next       = free_reg;
        held_next       = held_reg;
        free_save_next  = free_save_reg;
        held_save_next  = held_save_reg;
        ptr_next        = ptr_reg;
        done_next       = done_reg;
        progress_next   = progress_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        lane_load       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_POST;
                if (item_reg.cmd[CMD_CLEAR_BIT])
                begin
                    // clear reloads free counts and empties the table
                    free_next       = total_reg;
                    held_next       = '0;
                    res_status_next = ST_CLEARED;
                end
                else if (item_reg.cmd == CMD_RELEASE)
                begin
                    if (p_ok)
                    begin
                        free_next        = free_rel;
                        held_next[p_idx] = '0;
                    end
                    res_status_next = ST_RELEASED;
                end
                else if (!p_ok || (|over_vec))
                begin
                    res_status_next = ST_OVER_CLAIM;
                end
                else if (|short_vec)
                begin
                    res_status_next = ST_NOT_FREE;
                end
                else
                begin
                    // tentative allocation, then the safety scan
                    free_save_next   = free_reg;
                    held_save_next   = held_row;
                    free_next        = free_tent;
                    held_next[p_idx] = held_tent;
                    lane_load        = 1'b1;
                    ptr_next         = '0;
                    done_next        = '0;
                    progress_next    = 1'b0;
                    state_next       = S_SCAN;
                end
            end

            S_SCAN:
            begin
                done_next     = done_upd;
                progress_next = prog_now;
                if (!last)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                else if (&done_upd)
                begin
                    res_status_next = ST_GRANTED;
                    state_next      = S_POST;
                end
                else if (prog_now)
                begin
                    // another pass while something finished this one
                    ptr_next      = '0;
                    progress_next = 1'b0;
                end
                else
                begin
                    // unsafe: roll the tentative allocation back
                    free_next        = free_save_reg;
                    held_next[p_idx] = held_save_reg;
                    res_status_next  = ST_UNSAFE;
                    state_next       = S_POST;
                end
            end

            S_POST:
            begin
                // hand the result over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{status: res_status_reg, free_units: free_reg};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and allocation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_reg      <= FREE_RESET;
            held_reg      <= '0;
            ptr_reg       <= '0;
            done_reg      <= '0;
            progress_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            claim_reg     <= CLAIM_RESET;
            total_reg     <= TOTAL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            held_reg      <= held_next;
            ptr_reg       <= ptr_next;
            done_reg      <= done_next;
            progress_reg  <= progress_next;
            out_valid_reg <= out_valid_next;
            // config writes; indexes past the total register are dropped
            if (cfg_we)
            begin
                for (int i = 0; i < NPROC; i++)
                begin
                    if (cfg_index == CFG_IDX_W'(i))
                    begin
                        claim_reg[i] <= cfg_data;
                    end
                end
                if (cfg_index == CFG_TOTAL)
                begin
                    total_reg <= cfg_data;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        free_save_reg  <= free_save_next;
        held_save_reg  <= held_save_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

`ifndef SYNTH
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(ptr_reg) < NPROC)
        else $error("scan pointer out of range");

    a_grant_all_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POST && res_status_reg == ST_GRANTED) |-> (&done_reg))
        else $error("grant without every process finishing");

    a_unsafe_rollback: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && state_next == S_POST && res_status_next == ST_UNSAFE)
        |=> (free_reg == free_save_reg))
        else $error("free counts not restored after unsafe request");

    a_result_free: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (out_data_reg.free_units == free_reg))
        else $error("result free units differ from free counts");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("accepted item not executed");
`endif

endmodule
